// File: rtl/core/pqp_pkg.sv
`default_nettype none

package pqp_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int GAIN_FRAC_BITS_DEF = 12;

    localparam int GAIN_W      = 24;
    localparam int LIMIT_W     = 24;
    localparam int DRIVE_LIM_W = 31;
    localparam int ESUM_W      = 25;
    localparam int DRIVE_W     = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_ADDR_W-1:0] CFG_QUAD_GAIN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTEG_GAIN  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DERIV_GAIN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_LIMIT = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_ISUM,
        ST_QLO,
        ST_QHI,
        ST_PLIN,
        ST_ITERM,
        ST_DTERM,
        ST_FLUSH,
        ST_CLAMP
    } seq_state_t;

    typedef struct packed {
        logic en;
        logic hi;
    } acc_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/positional_pid_quadratic_p_top.sv
// Positional PID controller with a sign-preserving quadratic proportional term.
// Input channel s_*: one transaction carries a setpoint and a measured sample.
// Result channel m_*: one transaction per input, m_tdata is the drive value and
// m_tuser flags that the output clamp acted.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (gains, integral
// limit, drive limit); write only while the block is idle.
// No new item is taken until the last one has left the clamp step. The single
// shared multiplier is used in six consecutive steps (error square, quadratic
// low and high halves, proportional, integral, derivative), framed by error,
// accumulate and clamp steps; s_tready stays low while these run.
// The result sits in an output register; a new item is accepted while it waits.
// When m_tready is held low, the sequencer waits in its clamp step until the
// held result is taken.
// Reset clears the integral, the previous error and all gains and the integral
// limit; the drive limit resets to its maximum.
`default_nettype none

module positional_pid_quadratic_p_top #(
    parameter int SAMPLE_BITS    = pqp_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = pqp_pkg::GAIN_FRAC_BITS_DEF,
    localparam int S_TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pqp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pqp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_TDATA_W-1:0]            s_tdata,   // setpoint, measured
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pqp_pkg::DRIVE_W-1:0]     m_tdata,   // drive
    output logic [0:0]                      m_tuser    // clamped
);

    import pqp_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int ERR_W  = SB + 1;
    localparam int DIFF_W = SB + 2;
    localparam int OPW    = (SB + 2 > ESUM_W) ? SB + 2 : ESUM_W;
    localparam int PW     = 2 * OPW;
    localparam int LOW    = SB + 1;
    localparam int ACCW   = PW + SB + 2;
    localparam int ISUM_W = ((ESUM_W > ERR_W) ? ESUM_W : ERR_W) + 1;

    logic signed [GAIN_W-1:0]  quad_gain_reg;
    logic signed [GAIN_W-1:0]  prop_gain_reg;
    logic signed [GAIN_W-1:0]  integ_gain_reg;
    logic signed [GAIN_W-1:0]  deriv_gain_reg;
    logic [LIMIT_W-1:0]        integ_limit_reg;
    logic [DRIVE_LIM_W-1:0]    drive_limit_reg;

    seq_state_t                state_reg;
    seq_state_t                state_next;
    logic signed [SB-1:0]      sp_reg;
    logic signed [SB-1:0]      ms_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic signed [ESUM_W-1:0]  esum_reg;
    logic signed [LOW-1:0]     sqhi_reg;
    logic signed [ACCW-1:0]    acc_reg;
    acc_ctl_t                  pend_reg;
    acc_ctl_t                  pend_next;
    logic [DRIVE_W-1:0]        drive_reg;
    logic                      clamp_reg;
    logic                      m_valid_reg;

    logic                      mul_en;
    logic signed [OPW-1:0]     mul_a;
    logic signed [OPW-1:0]     mul_b;
    logic signed [PW-1:0]      prod;

    logic signed [ERR_W-1:0]   err_c;
    logic signed [DIFF_W-1:0]  diff_c;
    logic [ERR_W-1:0]          abs_err_c;
    logic signed [ISUM_W-1:0]  isum_c;
    logic signed [ISUM_W-1:0]  ilim_c;
    logic signed [ACCW-1:0]    addend_c;
    logic signed [ACCW-1:0]    y_c;
    logic signed [ACCW-1:0]    dlim_c;
    logic                      out_free;

    pqp_mul #(
        .OPW (OPW)
    ) u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = clamp_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign err_c     = ERR_W'(sp_reg) - ERR_W'(ms_reg);
    assign diff_c    = DIFF_W'(err_c) - DIFF_W'(last_err_reg);
    assign abs_err_c = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign isum_c    = ISUM_W'(esum_reg) + ISUM_W'(err_reg);
    assign ilim_c    = $signed({{(ISUM_W-LIMIT_W){1'b0}}, integ_limit_reg});
    assign addend_c  = pend_reg.hi ? (ACCW'(prod) <<< LOW) : ACCW'(prod);
    assign y_c       = acc_reg >>> GAIN_FRAC_BITS;
    assign dlim_c    = $signed({{(ACCW-DRIVE_LIM_W){1'b0}}, drive_limit_reg});

    always_comb begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        pend_next  = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                state_next = ST_ISUM;
            end
            ST_ISUM: begin
                mul_en     = 1'b1;
                mul_a      = OPW'(err_reg);
                mul_b      = $signed({{(OPW-ERR_W){1'b0}}, abs_err_c});
                state_next = ST_QLO;
            end
            ST_QLO: begin
                mul_en     = 1'b1;
                mul_a      = OPW'(quad_gain_reg);
                mul_b      = $signed({{(OPW-LOW){1'b0}}, prod[LOW-1:0]});
                pend_next  = '{en: 1'b1, hi: 1'b0};
                state_next = ST_QHI;
            end
            ST_QHI: begin
                mul_en     = 1'b1;
                mul_a      = OPW'(quad_gain_reg);
                mul_b      = OPW'(sqhi_reg);
                pend_next  = '{en: 1'b1, hi: 1'b1};
                state_next = ST_PLIN;
            end
            ST_PLIN: begin
                mul_en     = 1'b1;
                mul_a      = OPW'(prop_gain_reg);
                mul_b      = OPW'(err_reg);
                pend_next  = '{en: 1'b1, hi: 1'b0};
                state_next = ST_ITERM;
            end
            ST_ITERM: begin
                mul_en     = 1'b1;
                mul_a      = OPW'(integ_gain_reg);
                mul_b      = OPW'(esum_reg);
                pend_next  = '{en: 1'b1, hi: 1'b0};
                state_next = ST_DTERM;
            end
            ST_DTERM: begin
                mul_en     = 1'b1;
                mul_a      = OPW'(deriv_gain_reg);
                mul_b      = OPW'(diff_reg);
                pend_next  = '{en: 1'b1, hi: 1'b0};
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (state_reg == ST_CLAMP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_gain_reg   <= '0;
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            integ_limit_reg <= '0;
            drive_limit_reg <= {DRIVE_LIM_W{1'b1}};
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_QUAD_GAIN:   quad_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                CFG_DRIVE_LIMIT: drive_limit_reg <= cfg_wdata[DRIVE_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esum_reg     <= '0;
            last_err_reg <= '0;
        end else begin
            case (state_reg)
                ST_ERR: begin
                    last_err_reg <= err_c;
                end
                ST_ISUM: begin
                    if (isum_c > ilim_c) begin
                        esum_reg <= ESUM_W'(ilim_c);
                    end else if (isum_c < -ilim_c) begin
                        esum_reg <= ESUM_W'(-ilim_c);
                    end else begin
                        esum_reg <= ESUM_W'(isum_c);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sp_reg <= s_tdata[SB-1:0];
            ms_reg <= s_tdata[2*SB-1:SB];
        end
        if (state_reg == ST_ERR) begin
            err_reg  <= err_c;
            diff_reg <= diff_c;
        end
        if (state_reg == ST_QLO) begin
            sqhi_reg <= prod[2*SB+1:LOW];
        end
        if (state_reg == ST_ISUM) begin
            acc_reg <= '0;
        end else if (pend_reg.en) begin
            acc_reg <= acc_reg + addend_c;
        end
        if (state_reg == ST_CLAMP && out_free) begin
            if (y_c > dlim_c) begin
                drive_reg <= DRIVE_W'(dlim_c);
                clamp_reg <= 1'b1;
            end else if (y_c < -dlim_c) begin
                drive_reg <= DRIVE_W'(-dlim_c);
                clamp_reg <= 1'b1;
            end else begin
                drive_reg <= DRIVE_W'(y_c);
                clamp_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pqp_mul.sv
`default_nettype none

module pqp_mul #(
    parameter int OPW = 25
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [OPW-1:0] op_a,
    input  logic signed [OPW-1:0] op_b,
    output logic signed [2*OPW-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pqp_checker.sv
`default_nettype none

module pqp_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [pqp_pkg::DRIVE_W-1:0]  m_tdata,
    input  logic [0:0]                   m_tuser
);

    import pqp_pkg::*;

    localparam logic [DRIVE_W-1:0] MOST_NEG = {1'b1, {(DRIVE_W-1){1'b0}}};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken while a sample is in progress");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != MOST_NEG)
        else $error("drive outside the symmetric limit");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented straight after reset");

endmodule

bind positional_pid_quadratic_p_top pqp_checker u_pqp_checker (.*);

`default_nettype wire
